// ----- hw/rtl/lrp_pkg.sv -----
// Shared types and constants for the largest-remainder percent block.
package lrp_pkg;

  localparam int CNT_W     = 48;
  localparam int SHARE_W   = 7;
  localparam int QBITS     = 7;
  localparam int SCALED_W  = 56;
  localparam int LANE_MAX  = 4;
  localparam int TOTAL_W   = 9;
  localparam int LANE_LAT  = 8;
  localparam int MERGE_LAT = 2;

  localparam logic [SHARE_W-1:0] PCT_FULL = 7'd100;

  typedef struct packed {
    logic [SHARE_W-1:0] share;
    logic [CNT_W-1:0]   rem;
    logic               clip;
  } lane_res_t;

endpackage

// ----- hw/rtl/lrp_div_lane.sv -----
// One lane: scale a part by 100 and divide by the whole over seven restoring steps.
module lrp_div_lane (
  input  logic                       clk,
  input  logic                       adv,
  input  logic                       en,
  input  logic [lrp_pkg::CNT_W-1:0]  part,
  input  logic [lrp_pkg::CNT_W-1:0]  whole,
  output lrp_pkg::lane_res_t         res
);

  localparam int NS = lrp_pkg::QBITS + 1;

  logic [lrp_pkg::SCALED_W-1:0] rem  [NS];
  logic [lrp_pkg::CNT_W-1:0]    whl  [NS];
  logic [lrp_pkg::QBITS-1:0]    quo  [NS];
  logic                         act  [NS];
  logic                         clip [NS];

  logic [lrp_pkg::SCALED_W-1:0] scaled;
  logic [lrp_pkg::SCALED_W-1:0] lim;
  logic                         over;

  always_comb begin
    scaled = ({8'd0, part} << 6) + ({8'd0, part} << 5) + ({8'd0, part} << 2);
    lim    = ({8'd0, whole} << 6) + ({8'd0, whole} << 5) + ({8'd0, whole} << 2)
             + {8'd0, whole};
    over   = en && (scaled >= lim);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act[0]  <= en && !over;
      clip[0] <= over;
      whl[0]  <= whole;
      quo[0]  <= '0;
      rem[0]  <= (en && !over) ? scaled : '0;
      for (int s = 1; s < NS; s++) begin
        act[s]  <= act[s-1];
        clip[s] <= clip[s-1];
        whl[s]  <= whl[s-1];
        if (act[s-1] && (rem[s-1] >= (lrp_pkg::SCALED_W'(whl[s-1]) << (NS-1-s)))) begin
          rem[s] <= rem[s-1] - (lrp_pkg::SCALED_W'(whl[s-1]) << (NS-1-s));
          quo[s] <= quo[s-1] | (lrp_pkg::QBITS'(1) << (NS-1-s));
        end else begin
          rem[s] <= rem[s-1];
          quo[s] <= quo[s-1];
        end
      end
    end
  end

  always_comb begin
    res.share = clip[NS-1] ? lrp_pkg::PCT_FULL : quo[NS-1];
    res.rem   = rem[NS-1][lrp_pkg::CNT_W-1:0];
    res.clip  = clip[NS-1];
  end

endmodule

// ----- hw/rtl/lrp_merge.sv -----
// Merge stage: rank lane remainders and hand out the missing units.
module lrp_merge #(
  parameter int LANES = 4
) (
  input  logic                              clk,
  input  logic                              adv,
  input  lrp_pkg::lane_res_t                lane [LANES],
  output logic [lrp_pkg::SHARE_W-1:0]       share [LANES],
  output logic                              clipped
);

  localparam int RANK_W = $clog2(LANES + 1);

  logic [LANES-1:0]               beats [LANES];
  logic [LANES-1:0]               nz;
  logic [lrp_pkg::SHARE_W-1:0]    base [LANES];
  logic [lrp_pkg::TOTAL_W-1:0]    total;
  logic                           clip_a;

  logic [lrp_pkg::TOTAL_W-1:0]    total_next;
  logic [lrp_pkg::TOTAL_W-1:0]    deficit;
  logic [RANK_W-1:0]              rank [LANES];

  always_comb begin
    total_next = '0;
    for (int i = 0; i < LANES; i++) begin
      total_next = total_next + lrp_pkg::TOTAL_W'(lane[i].share);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      total  <= total_next;
      clip_a <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        base[i] <= lane[i].share;
        nz[i]   <= lane[i].rem != '0;
        if (lane[i].clip) begin
          clip_a <= 1'b1;
        end
        for (int j = 0; j < LANES; j++) begin
          beats[i][j] <= (lane[j].rem != '0) &&
                         ((lane[j].rem > lane[i].rem) ||
                          ((lane[j].rem == lane[i].rem) && (j < i)));
        end
      end
    end
  end

  always_comb begin
    deficit = (total < lrp_pkg::TOTAL_W'(lrp_pkg::PCT_FULL)) ?
              lrp_pkg::TOTAL_W'(lrp_pkg::PCT_FULL) - total : '0;
    for (int i = 0; i < LANES; i++) begin
      rank[i] = '0;
      for (int j = 0; j < LANES; j++) begin
        rank[i] = rank[i] + RANK_W'(beats[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clipped <= clip_a;
      for (int i = 0; i < LANES; i++) begin
        share[i] <= (nz[i] && (lrp_pkg::TOTAL_W'(rank[i]) < deficit)) ?
                    base[i] + 7'd1 : base[i];
      end
    end
  end

endmodule

// ----- hw/rtl/largest_remainder_percent.sv -----
// Throughput: one item per cycle while the output is not stalled; each lane divides through an 8-stage
// restoring pipeline and a 2-stage merge ranks the remainders.
// The pipeline stalls as a whole only when the output register holds an
// item that is not taken. Reset clears the valid bits only; the data registers are not reset.
module largest_remainder_percent #(
  parameter int NUM_PARTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] part_0,
  input  logic [47:0] part_1,
  input  logic [47:0] part_2,
  input  logic [47:0] part_3,
  input  logic [2:0]  part_count,
  input  logic [47:0] whole,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  share_0,
  output logic [6:0]  share_1,
  output logic [6:0]  share_2,
  output logic [6:0]  share_3,
  output logic        whole_was_zero,
  output logic        share_clipped
);

  localparam int LANES = (NUM_PARTS < lrp_pkg::LANE_MAX) ? NUM_PARTS : lrp_pkg::LANE_MAX;
  localparam int DEPTH = lrp_pkg::LANE_LAT + lrp_pkg::MERGE_LAT;

  logic                          adv;
  logic [DEPTH-1:0]              vld;
  logic [DEPTH-1:0]              wz;
  logic [lrp_pkg::CNT_W-1:0]     parts [lrp_pkg::LANE_MAX];
  lrp_pkg::lane_res_t            lane_res [LANES];
  logic [lrp_pkg::SHARE_W-1:0]   merged [LANES];
  logic [lrp_pkg::SHARE_W-1:0]   shares [lrp_pkg::LANE_MAX];
  logic                          clipped;
  logic                          count_ok;

  assign adv       = !vld[DEPTH-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld[DEPTH-1];
  assign count_ok  = (whole != '0) && (part_count <= 3'(LANES));

  assign parts[0] = part_0;
  assign parts[1] = part_1;
  assign parts[2] = part_2;
  assign parts[3] = part_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wz <= {wz[DEPTH-2:0], whole == '0};
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    lrp_div_lane u_lane (
      .clk   (clk),
      .adv   (adv),
      .en    (count_ok && (3'(i) < part_count)),
      .part  (parts[i]),
      .whole (whole),
      .res   (lane_res[i])
    );
  end

  lrp_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk     (clk),
    .adv     (adv),
    .lane    (lane_res),
    .share   (merged),
    .clipped (clipped)
  );

  for (genvar i = 0; i < lrp_pkg::LANE_MAX; i++) begin : g_out
    if (i < LANES) begin : g_used
      assign shares[i] = merged[i];
    end else begin : g_zero
      assign shares[i] = '0;
    end
  end

  assign share_0        = shares[0];
  assign share_1        = shares[1];
  assign share_2        = shares[2];
  assign share_3        = shares[3];
  assign whole_was_zero = wz[DEPTH-1];
  assign share_clipped  = clipped;

endmodule
